@@ hdl/pkha_pkg.sv @@
package pkha_pkg;

	localparam int NODE_BITS        = 20;
	localparam int AMOUNT_BITS      = 32;
	localparam int LIMIT_BITS       = 11;
	localparam int REQ_BITS         = 2;
	localparam int STATUS_BITS      = 2;
	localparam int IN_DATA_BITS     = 72;
	localparam int OUT_USER_BITS    = 3;
	localparam int SLOTS_DEFAULT    = 1024;
	localparam logic [LIMIT_BITS-1:0] LOAD_LIMIT_RESET = 11'd768;

	// double hashing constants
	localparam int POS_BASE  = 25205;
	localparam int POS_MUL   = 71;
	localparam int STEP_BASE = 65863;
	localparam int STEP_MUL  = 97;

	typedef enum logic [REQ_BITS-1:0] {
		REQ_ADD    = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_CLEAR  = 2'd2
	} req_type_t;

	typedef enum logic [STATUS_BITS-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_ZERO_AMT = 2'd2,
		STAT_NO_SLOT  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_PROBE_RD,
		ST_PROBE_CHK,
		ST_UPDATE,
		ST_CLR_RD,
		ST_CLR_WR,
		ST_RESPOND
	} state_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_EMPTY,
		RES_ZERO_AMT,
		RES_NO_SLOT,
		RES_UPDATE
	} res_sel_t;

	typedef struct packed {
		logic     in_ready;
		logic     capture;
		logic     cnt_clr;
		logic     cnt_inc;
		logic     hash;
		logic     probe_rd;
		logic     probe_next;
		logic     init_wr;
		logic     list_rd;
		logic     clr_wr;
		logic     clr_done;
		res_sel_t res_sel;
		logic     out_load;
	} pkha_cmd_t;

	typedef struct packed {
		logic [REQ_BITS-1:0] req_type;
		logic                amount_zero;
		logic                hit;
		logic                cnt_last;
		logic                list_done;
		logic                out_free;
	} pkha_stat_t;

endpackage

@@ hdl/pkha_ctrl.sv @@
module pkha_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  pkha_pkg::pkha_stat_t stat,
	output pkha_pkg::pkha_cmd_t  cmd
);
	import pkha_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.res_sel = RES_NONE;
		state_nxt   = state_q;
		case (state_q)
			ST_INIT: begin
				// sweep every slot to empty after reset
				cmd.init_wr = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (stat.cnt_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					cmd.cnt_clr = 1'b1;
					state_nxt   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (stat.req_type)
					REQ_ADD: begin
						if (stat.amount_zero) begin
							cmd.res_sel = RES_ZERO_AMT;
							state_nxt   = ST_RESPOND;
						end else begin
							cmd.hash  = 1'b1;
							state_nxt = ST_PROBE_RD;
						end
					end
					REQ_LOOKUP: begin
						cmd.hash  = 1'b1;
						state_nxt = ST_PROBE_RD;
					end
					REQ_CLEAR: begin
						state_nxt = ST_CLR_RD;
					end
					default: begin
						cmd.res_sel = RES_EMPTY;
						state_nxt   = ST_RESPOND;
					end
				endcase
			end
			ST_PROBE_RD: begin
				cmd.probe_rd = 1'b1;
				state_nxt    = ST_PROBE_CHK;
			end
			ST_PROBE_CHK: begin
				if (stat.hit) begin
					state_nxt = ST_UPDATE;
				end else if (stat.cnt_last) begin
					cmd.res_sel = RES_NO_SLOT;
					state_nxt   = ST_RESPOND;
				end else begin
					cmd.probe_next = 1'b1;
					cmd.cnt_inc    = 1'b1;
					state_nxt      = ST_PROBE_RD;
				end
			end
			ST_UPDATE: begin
				cmd.res_sel = RES_UPDATE;
				state_nxt   = ST_RESPOND;
			end
			ST_CLR_RD: begin
				if (stat.list_done) begin
					cmd.clr_done = 1'b1;
					cmd.res_sel  = RES_EMPTY;
					state_nxt    = ST_RESPOND;
				end else begin
					cmd.list_rd = 1'b1;
					state_nxt   = ST_CLR_WR;
				end
			end
			ST_CLR_WR: begin
				cmd.clr_wr  = 1'b1;
				cmd.cnt_inc = 1'b1;
				state_nxt   = ST_CLR_RD;
			end
			ST_RESPOND: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/pkha_datapath.sv @@
module pkha_datapath #(
	parameter int SLOTS = pkha_pkg::SLOTS_DEFAULT
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  pkha_pkg::pkha_cmd_t                     cmd,
	output pkha_pkg::pkha_stat_t                    stat,
	input  logic [pkha_pkg::IN_DATA_BITS-1:0]       in_data,
	input  logic [pkha_pkg::REQ_BITS-1:0]           in_user,
	input  logic                                    cfg_valid,
	input  logic [pkha_pkg::LIMIT_BITS-1:0]         cfg_data,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [pkha_pkg::AMOUNT_BITS-1:0]        out_data,
	output logic [pkha_pkg::OUT_USER_BITS-1:0]      out_user
);
	import pkha_pkg::*;

	localparam int IW   = $clog2(SLOTS);
	localparam int CW   = IW + 1;
	localparam int CMPW = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;
	localparam int KEYW = 2 * NODE_BITS;

	// slot store
	logic [KEYW-1:0]        key_mem   [SLOTS];
	logic [AMOUNT_BITS-1:0] total_mem [SLOTS];
	logic [IW-1:0]          list_mem  [SLOTS];

	logic [REQ_BITS-1:0]    req_q;
	logic [NODE_BITS-1:0]   first_q;
	logic [NODE_BITS-1:0]   second_q;
	logic [AMOUNT_BITS-1:0] amount_q;
	logic [IW-1:0]          pos_q;
	logic [IW-1:0]          step_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          key_count_q;
	logic [LIMIT_BITS-1:0]  limit_q;

	logic [KEYW-1:0]        key_rd_q;
	logic [AMOUNT_BITS-1:0] total_rd_q;
	logic [IW-1:0]          list_rd_q;

	logic [AMOUNT_BITS-1:0] res_total_q;
	logic                   res_new_q;
	logic [STATUS_BITS-1:0] res_status_q;

	logic                   out_valid_q;
	logic [AMOUNT_BITS-1:0] out_total_q;
	logic                   out_new_q;
	logic [STATUS_BITS-1:0] out_status_q;

	logic                   is_add;
	logic                   slot_empty;
	logic                   table_full;
	logic                   do_update;
	logic                   new_ok;
	logic [AMOUNT_BITS:0]   sum;
	logic [AMOUNT_BITS-1:0] upd_total;
	logic                   tot_we;
	logic [IW-1:0]          tot_waddr;
	logic [AMOUNT_BITS-1:0] tot_wdata;

	always_comb begin
		is_add     = (req_q == REQ_ADD);
		slot_empty = (total_rd_q == '0);
		table_full = (CMPW'(key_count_q) >= CMPW'(limit_q)) || (key_count_q >= CW'(SLOTS));
		do_update  = (cmd.res_sel == RES_UPDATE);
		new_ok     = do_update && is_add && slot_empty && !table_full;
		sum        = {1'b0, total_rd_q} + {1'b0, amount_q};
		// saturate on carry out
		upd_total  = slot_empty ? amount_q : (sum[AMOUNT_BITS] ? '1 : sum[AMOUNT_BITS-1:0]);

		tot_we    = cmd.init_wr || cmd.clr_wr ||
		            (do_update && is_add && !(slot_empty && table_full));
		tot_waddr = cmd.init_wr ? cnt_q[IW-1:0] : (cmd.clr_wr ? list_rd_q : pos_q);
		tot_wdata = (cmd.init_wr || cmd.clr_wr) ? '0 : upd_total;
	end

	always_comb begin
		stat.req_type    = req_q;
		stat.amount_zero = (amount_q == '0);
		stat.hit         = (total_rd_q == '0) || (key_rd_q == {second_q, first_q});
		stat.cnt_last    = (cnt_q == CW'(SLOTS - 1));
		stat.list_done   = (cnt_q == key_count_q);
		stat.out_free    = !out_valid_q || out_ready;
	end

	// memories
	always_ff @(posedge clk) begin
		if (tot_we) begin
			total_mem[tot_waddr] <= tot_wdata;
		end
		if (cmd.probe_rd) begin
			total_rd_q <= total_mem[pos_q];
		end
	end

	always_ff @(posedge clk) begin
		if (new_ok) begin
			key_mem[pos_q] <= {second_q, first_q};
		end
		if (cmd.probe_rd) begin
			key_rd_q <= key_mem[pos_q];
		end
	end

	always_ff @(posedge clk) begin
		if (new_ok) begin
			list_mem[key_count_q[IW-1:0]] <= pos_q;
		end
		if (cmd.list_rd) begin
			list_rd_q <= list_mem[cnt_q[IW-1:0]];
		end
	end

	// request payload and probe position
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q    <= in_user;
			first_q  <= in_data[NODE_BITS-1:0];
			second_q <= in_data[2*NODE_BITS-1:NODE_BITS];
			amount_q <= in_data[2*NODE_BITS+AMOUNT_BITS-1:2*NODE_BITS];
		end
		if (cmd.hash) begin
			pos_q  <= IW'(POS_BASE) + IW'(POS_MUL) * first_q[IW-1:0] + second_q[IW-1:0];
			step_q <= (IW'(STEP_BASE) + IW'(STEP_MUL) * first_q[IW-1:0] + second_q[IW-1:0])
			          | IW'(1);
		end else if (cmd.probe_next) begin
			pos_q <= pos_q + step_q;
		end
	end

	// result held until the output register frees up
	always_ff @(posedge clk) begin
		case (cmd.res_sel)
			RES_EMPTY: begin
				res_total_q  <= '0;
				res_new_q    <= 1'b0;
				res_status_q <= STAT_OK;
			end
			RES_ZERO_AMT: begin
				res_total_q  <= '0;
				res_new_q    <= 1'b0;
				res_status_q <= STAT_ZERO_AMT;
			end
			RES_NO_SLOT: begin
				res_total_q  <= '0;
				res_new_q    <= 1'b0;
				res_status_q <= STAT_NO_SLOT;
			end
			RES_UPDATE: begin
				if (!is_add) begin
					res_total_q  <= total_rd_q;
					res_new_q    <= 1'b0;
					res_status_q <= STAT_OK;
				end else if (slot_empty && table_full) begin
					res_total_q  <= '0;
					res_new_q    <= 1'b0;
					res_status_q <= STAT_FULL;
				end else begin
					res_total_q  <= upd_total;
					res_new_q    <= slot_empty;
					res_status_q <= STAT_OK;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_total_q  <= res_total_q;
			out_new_q    <= res_new_q;
			out_status_q <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			key_count_q <= '0;
			limit_q     <= LOAD_LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.clr_done) begin
				key_count_q <= '0;
			end else if (new_ok) begin
				key_count_q <= key_count_q + CW'(1);
			end
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_total_q;
	assign out_user  = {out_status_q, out_new_q};

endmodule

@@ hdl/pair_key_hash_accumulator.sv @@
// Accumulating hash table keyed by a (first_node, second_node) pair, with
// double hashing over SLOTS slots (a power of two) and saturating unsigned
// Q1.31 totals. Requests are handled one at a time. After reset the block
// runs a clearing pass over the slot memory and takes no request until it
// ends; configuration writes are taken at any time. An add or lookup makes
// p probes (1 to SLOTS) between transfer in and result out: each probe is a
// read of the registered slot memory followed by a compare. When all SLOTS
// probes miss, the update step is skipped. A clear does one list read and
// one slot write per stored key. A zero-amount add or an unused request
// type goes from decode straight to the response. The block returns to idle
// before the next request is taken; a finished result waits in the output
// register without holding up the next request's work.
module pair_key_hash_accumulator #(
	parameter int SLOTS = pkha_pkg::SLOTS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// first_node[19:0], second_node[39:20], amount[71:40]
	input  logic [pkha_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
	// req_type[1:0]
	input  logic [pkha_pkg::REQ_BITS-1:0]        s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// total[31:0]
	output logic [pkha_pkg::AMOUNT_BITS-1:0]     m_axis_tdata,
	// was_new[0], status[2:1]
	output logic [pkha_pkg::OUT_USER_BITS-1:0]   m_axis_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pkha_pkg::LIMIT_BITS-1:0]      cfg_data
);
	import pkha_pkg::*;

	pkha_cmd_t  cmd;
	pkha_stat_t stat;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = cmd.in_ready;

	pkha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.stat     (stat),
		.cmd      (cmd)
	);

	pkha_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule

@@ tb/pair_table_checker.sv @@
`timescale 1ns / 100ps
module pair_table_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	input  logic                                   s_axis_tready,
	// first_node[19:0], second_node[39:20], amount[71:40]
	input  logic [pkha_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,
	// req_type[1:0]
	input  logic [pkha_pkg::REQ_BITS-1:0]          s_axis_tuser,
	input  logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// total[31:0]
	input  logic [pkha_pkg::AMOUNT_BITS-1:0]       m_axis_tdata,
	// was_new[0], status[2:1]
	input  logic [pkha_pkg::OUT_USER_BITS-1:0]     m_axis_tuser,
	input  logic                                   cfg_valid,
	input  logic                                   cfg_ready,
	input  logic [pkha_pkg::LIMIT_BITS-1:0]        cfg_data,
	output int                                     fail_count,
	output int                                     open_count
);
	import pkha_pkg::*;

	localparam int SLOTS     = SLOTS_DEFAULT;
	localparam int SLOT_BITS = $clog2(SLOTS);

	typedef struct packed {
		logic [AMOUNT_BITS-1:0] total;
		logic                   was_new;
		status_t                status;
	} table_result_t;

	logic [NODE_BITS-1:0]   key_first  [SLOTS];
	logic [NODE_BITS-1:0]   key_second [SLOTS];
	logic [AMOUNT_BITS-1:0] slot_sum   [SLOTS];
	logic [SLOT_BITS-1:0]   fill_order [SLOTS];
	int unsigned            stored_keys;
	logic [LIMIT_BITS-1:0]  key_limit;
	table_result_t          due_results [$];

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			key_first[i]  = '0;
			key_second[i] = '0;
			slot_sum[i]   = '0;
			fill_order[i] = '0;
		end
		stored_keys = 0;
		key_limit   = LOAD_LIMIT_RESET;
		fail_count  = 0;
	end

	// double hashing walk, stops on an empty slot or the key itself
	function automatic logic find_slot_for(input logic [NODE_BITS-1:0] a,
			input logic [NODE_BITS-1:0] b, output int unsigned slot);
		logic [63:0] pos;
		logic [63:0] stride;
		pos    = 64'(POS_BASE) + 64'(POS_MUL) * a + b;
		stride = 64'(STEP_BASE) + 64'(STEP_MUL) * a + b;
		if (!stride[0])
			stride = stride + 64'd1;
		slot = 0;
		for (int k = 0; k < SLOTS; k++) begin
			slot = int'(pos % SLOTS);
			if (slot_sum[slot] == '0 || (key_first[slot] == a && key_second[slot] == b))
				return 1'b1;
			pos = pos + stride;
		end
		return 1'b0;
	endfunction

	function automatic table_result_t apply_request(input logic [REQ_BITS-1:0] req,
			input logic [NODE_BITS-1:0] a, input logic [NODE_BITS-1:0] b,
			input logic [AMOUNT_BITS-1:0] amount);
		table_result_t res;
		int unsigned slot;
		logic [AMOUNT_BITS:0] sum;
		res.total   = '0;
		res.was_new = 1'b0;
		res.status  = STAT_OK;
		case (req)
			REQ_ADD: begin
				if (amount == '0)
					res.status = STAT_ZERO_AMT;
				else if (!find_slot_for(a, b, slot))
					res.status = STAT_NO_SLOT;
				else if (slot_sum[slot] == '0) begin
					if (stored_keys >= key_limit || stored_keys >= SLOTS)
						res.status = STAT_FULL;
					else begin
						fill_order[stored_keys] = SLOT_BITS'(slot);
						stored_keys++;
						key_first[slot]  = a;
						key_second[slot] = b;
						slot_sum[slot]   = amount;
						res.total        = amount;
						res.was_new      = 1'b1;
					end
				end else begin
					sum = {1'b0, slot_sum[slot]} + {1'b0, amount};
					slot_sum[slot] = sum[AMOUNT_BITS] ? '1 : sum[AMOUNT_BITS-1:0];
					res.total = slot_sum[slot];
				end
			end
			REQ_LOOKUP: begin
				if (find_slot_for(a, b, slot))
					res.total = slot_sum[slot];
				else
					res.status = STAT_NO_SLOT;
			end
			REQ_CLEAR: begin
				// only slots taken since the last clear are zeroed
				for (int j = 0; j < stored_keys; j++)
					slot_sum[fill_order[j]] = '0;
				stored_keys = 0;
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk) begin : watch
		table_result_t seen;
		table_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				key_limit = cfg_data;
			if (m_axis_tvalid && m_axis_tready) begin
				seen.total   = m_axis_tdata;
				seen.was_new = m_axis_tuser[0];
				seen.status  = status_t'(m_axis_tuser[2:1]);
				if (due_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: total %h was_new %0d status %0d",
							seen.total, seen.was_new, seen.status);
				end else begin
					want = due_results.pop_front();
					if (seen !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: total exp %h got %h, ",
								"was_new exp %0d got %0d, status exp %0d got %0d"},
								want.total, seen.total, want.was_new, seen.was_new,
								want.status, seen.status);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				due_results.push_back(apply_request(s_axis_tuser,
					s_axis_tdata[NODE_BITS-1:0],
					s_axis_tdata[2*NODE_BITS-1:NODE_BITS],
					s_axis_tdata[IN_DATA_BITS-1:2*NODE_BITS]));
			open_count <= due_results.size();
		end
	end

endmodule

@@ tb/pair_key_hash_accumulator_tb.sv @@
`timescale 1ns / 100ps
module pair_key_hash_accumulator_tb;
	import pkha_pkg::*;

	localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;
	localparam int SLOTS         = SLOTS_DEFAULT;
	localparam int CYCLE_LIMIT   = 8_000_000;
	localparam int SETTLE_CYCLES = 2 * SLOTS + 8;

	typedef struct packed {
		logic [NODE_BITS-1:0] first;
		logic [NODE_BITS-1:0] second;
	} node_pair_t;

	logic                       clk;
	logic                       arst_n        = 1'b0;
	logic                       s_axis_tvalid = 1'b0;
	logic                       s_axis_tready;
	logic [IN_DATA_BITS-1:0]    s_axis_tdata  = '0;
	logic [REQ_BITS-1:0]        s_axis_tuser  = '0;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	logic [AMOUNT_BITS-1:0]     m_axis_tdata;
	logic [OUT_USER_BITS-1:0]   m_axis_tuser;
	logic                       cfg_valid     = 1'b0;
	logic                       cfg_ready;
	logic [LIMIT_BITS-1:0]      cfg_data      = '0;
	int                         fail_count;
	int                         open_count;
	int                         send_idle     = 28;
	int                         recv_idle     = 70;
	int                         cycle_count   = 0;

	pair_key_hash_accumulator DUT (.*);

	pair_table_checker table_check (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// valid stays high between back-to-back transfers
	task automatic send_request(input logic [REQ_BITS-1:0] req,
			input logic [NODE_BITS-1:0] a, input logic [NODE_BITS-1:0] b,
			input logic [AMOUNT_BITS-1:0] amount);
		if ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {amount, b, a};
		s_axis_tuser  <= req;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain_table();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (open_count != 0) @(posedge clk);
	endtask

	task automatic set_load_limit(input int value);
		drain_table();
		cfg_valid <= 1'b1;
		cfg_data  <= LIMIT_BITS'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [AMOUNT_BITS-1:0] random_amount();
		int pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return '0;
		if (pick < 10)
			return '1;
		if (pick < 55)
			return AMOUNT_BITS'($urandom_range(65535, 1));
		return $urandom;
	endfunction

	task automatic run_mix(input int count, input int pool_size);
		node_pair_t pool [$];
		node_pair_t key;
		int pick;
		pool = {};
		while (pool.size() < pool_size) begin
			key.first  = NODE_BITS'($urandom);
			key.second = NODE_BITS'($urandom);
			pool.push_back(key);
			// same start slot as the previous key, so one of them has to probe on
			if ($urandom_range(1)) begin
				key.first  = key.first + 1;
				key.second = key.second - NODE_BITS'(POS_MUL);
				pool.push_back(key);
			end
		end
		for (int i = 0; i < count; i++) begin
			key  = pool[$urandom_range(pool.size() - 1)];
			pick = $urandom_range(99);
			if (pick < 45)
				send_request(REQ_ADD, key.first, key.second, random_amount());
			else if (pick < 55)
				send_request(REQ_ADD, NODE_BITS'($urandom), NODE_BITS'($urandom),
					random_amount());
			else if (pick < 85)
				send_request(REQ_LOOKUP, key.first, key.second, $urandom);
			else if (pick < 92)
				send_request(REQ_LOOKUP, NODE_BITS'($urandom), NODE_BITS'($urandom),
					$urandom);
			else if (pick < 96)
				send_request(REQ_UNUSED, NODE_BITS'($urandom), NODE_BITS'($urandom),
					$urandom);
			else
				send_request(REQ_CLEAR, NODE_BITS'($urandom), NODE_BITS'($urandom),
					$urandom);
		end
	endtask

	// every slot taken, then probes that wrap the whole table
	task automatic fill_table();
		node_pair_t stored [$];
		node_pair_t key;
		int pick;
		stored = {};
		send_request(REQ_CLEAR, '0, '0, '0);
		for (int i = 0; i < SLOTS; i++) begin
			// distinct low bits of first_node keep every key distinct
			key.first  = (NODE_BITS'($urandom) & ~NODE_BITS'(SLOTS - 1)) | NODE_BITS'(i);
			key.second = NODE_BITS'($urandom);
			stored.push_back(key);
			send_request(REQ_ADD, key.first, key.second, $urandom | 32'h1);
		end
		for (int i = 0; i < 3; i++) begin
			key = stored[$urandom_range(SLOTS - 1)];
			send_request(REQ_ADD, key.first, key.second ^ 1'b1, $urandom | 32'h1);
			send_request(REQ_LOOKUP, key.first, key.second ^ 1'b1, '0);
		end
		for (int i = 0; i < 6; i++) begin
			pick = $urandom_range(SLOTS - 1);
			send_request(REQ_LOOKUP, stored[pick].first, stored[pick].second, '0);
			send_request(REQ_ADD, stored[pick].first, stored[pick].second, random_amount());
		end
		send_request(REQ_CLEAR, '0, '0, '0);
		send_request(REQ_LOOKUP, stored[0].first, stored[0].second, '0);
		send_request(REQ_ADD, stored[1].first, stored[1].second, 32'h0000_0100);
		send_request(REQ_CLEAR, '0, '0, '0);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		send_request(REQ_LOOKUP, '0, '0, '0);
		send_request(REQ_ADD, '0, '0, '0);
		send_request(REQ_ADD, '0, '0, 32'h0000_0001);
		send_request(REQ_ADD, '0, '0, 32'hFFFF_FFFF);
		send_request(REQ_LOOKUP, '0, '0, 32'hFFFF_FFFF);
		send_request(REQ_ADD, '1, '1, 32'h8000_0000);
		send_request(REQ_ADD, '1, '1, 32'h7FFF_FFFF);
		send_request(REQ_ADD, '1, '1, 32'h0000_0001);
		// starts on the same slot as key (0, 0)
		send_request(REQ_ADD, 20'h00001, 20'hFFFB9, 32'h1234_5678);
		send_request(REQ_LOOKUP, 20'h00001, 20'hFFFB9, '0);
		send_request(REQ_LOOKUP, 20'h00000, 20'hFFFB9, '0);
		send_request(REQ_UNUSED, '1, '1, '1);
		send_request(REQ_UNUSED, '0, '0, '0);
		send_request(REQ_CLEAR, '1, '1, '1);
		send_request(REQ_LOOKUP, '0, '0, '0);
		send_request(REQ_LOOKUP, '1, '1, '0);
		send_request(REQ_ADD, '1, '1, 32'h0000_0005);
		send_request(REQ_CLEAR, '0, '0, '0);

		set_load_limit(1);
		send_request(REQ_ADD, 20'h12345, 20'hABCDE, 32'h0000_0007);
		send_request(REQ_ADD, 20'h54321, 20'hEDCBA, 32'h0000_0009);
		send_request(REQ_ADD, 20'h12345, 20'hABCDE, 32'h0000_0003);
		send_request(REQ_LOOKUP, 20'h54321, 20'hEDCBA, '0);
		send_request(REQ_ADD, 20'h54321, 20'hEDCBA, '0);
		send_request(REQ_CLEAR, '0, '0, '0);
		send_request(REQ_ADD, 20'h54321, 20'hEDCBA, 32'h0000_0009);
		send_request(REQ_CLEAR, '0, '0, '0);

		set_load_limit($urandom_range(40, 4));
		run_mix(24, 16);

		send_idle = 70;
		recv_idle = 28;
		set_load_limit(SLOTS);
		fill_table();

		send_idle = 0;
		recv_idle = 0;
		set_load_limit($urandom_range(SLOTS - 1, 200));
		run_mix(24, 48);
		set_load_limit($urandom_range(12, 2));
		run_mix(12, 20);

		drain_table();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && open_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
